// File: hdl/bsm_pkg.sv
// Shared constants, types and helpers for the byte substring matcher.
// No dependencies; imported by every module under hdl/.
package bsm_pkg;

    localparam int NUM_CELLS = 16;
    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 5;
    localparam int POS_W     = 17;
    localparam int BND_W     = 18;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int MODE_W    = 2;
    localparam int NEEDLE_W  = NUM_CELLS * CHAR_W;
    localparam int CIDX_W    = $clog2(NUM_CELLS);

    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PREFIX = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SUFFIX = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_HI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_START = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_END   = 3'd6;

    localparam logic [LEN_W-1:0] MAX_NEEDLE_LEN = LEN_W'(NUM_CELLS);

    typedef struct packed {
        logic              len_zero;
        logic [LEN_W-1:0]  len_act;
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  from;
        logic [POS_W-1:0]  to;
    } bsm_cfg_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] index;
        logic [POS_W-1:0] count;
    } bsm_res_t;

    function automatic logic [CHAR_W-1:0] needle_char(
        input logic [NEEDLE_W-1:0] needle,
        input logic [CIDX_W-1:0]   idx
    );
        return needle[idx*CHAR_W +: CHAR_W];
    endfunction

endpackage

// File: hdl/bsm_cell.sv
// One cell of the text shift line: holds one text byte, compares its next value
// with its needle byte and extends the match chain. Depends on bsm_pkg.
module bsm_cell (
    input  logic                       aclk,
    input  logic                       shift_en,
    input  logic [bsm_pkg::CHAR_W-1:0] data_in,
    input  logic [bsm_pkg::CHAR_W-1:0] pat_char,
    input  logic                       active,
    input  logic                       chain_in,
    output logic [bsm_pkg::CHAR_W-1:0] data_out,
    output logic                       chain_out
);
    import bsm_pkg::*;

    logic [CHAR_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= data_in;
        end
    end

    assign data_out  = data_reg;
    // inactive cells pass the chain through
    assign chain_out = chain_in & (!active | (data_in == pat_char));

endmodule

// File: hdl/bsm_track.sv
// Match trackers: position, first match in window, greedy count, prefix and
// suffix flags, and the result mux. Depends on bsm_pkg.
module bsm_track (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              has_byte,
    input  logic              last_item,
    input  logic              chain_hit,
    input  bsm_pkg::bsm_cfg_t cfg,
    output bsm_pkg::bsm_res_t res
);
    import bsm_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             fm_valid_reg, fm_valid_next;
    logic [POS_W-1:0] fm_idx_reg, fm_idx_next;
    logic [POS_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0] allow_reg, allow_next;
    logic             prefix_reg, prefix_next;
    logic             suffix_reg, suffix_next;

    logic             take;
    logic             hit;
    logic [POS_W-1:0] p1;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] len_ext;

    assign len_ext = POS_W'(cfg.len_act);
    assign take    = step & has_byte & !pos_reg[POS_W-1];
    assign p1      = pos_reg + POS_W'(1);
    assign start   = p1 - len_ext;
    assign hit     = take & !cfg.len_zero & chain_hit & (p1 >= len_ext);

    always_comb begin
        pos_next      = take ? p1 : pos_reg;
        fm_valid_next = fm_valid_reg;
        fm_idx_next   = fm_idx_reg;
        cnt_next      = cnt_reg;
        allow_next    = allow_reg;
        prefix_next   = prefix_reg;
        suffix_next   = take ? hit : suffix_reg;
        if (hit) begin
            if (!fm_valid_reg && (start >= cfg.from) && (p1 <= cfg.to)) begin
                fm_valid_next = 1'b1;
                fm_idx_next   = start;
            end
            if (start >= allow_reg) begin
                cnt_next   = cnt_reg + POS_W'(1);
                allow_next = p1;
            end
            if (start == '0) begin
                prefix_next = 1'b1;
            end
        end
    end

    always_comb begin
        res.found = 1'b0;
        res.index = '1;
        res.count = '0;
        unique case (cfg.mode)
            MODE_FIND: begin
                if (cfg.len_zero) begin
                    res.found = 1'b1;
                    res.index = cfg.from;
                end else begin
                    res.found = fm_valid_next;
                    res.index = fm_valid_next ? fm_idx_next : '1;
                end
            end
            MODE_COUNT: begin
                res.count = cfg.len_zero ? pos_next + POS_W'(1) : cnt_next;
                res.found = (res.count != '0);
            end
            MODE_PREFIX: res.found = cfg.len_zero | prefix_next;
            MODE_SUFFIX: res.found = cfg.len_zero | suffix_next;
            default: res.found = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_item)) begin
            pos_reg      <= '0;
            fm_valid_reg <= 1'b0;
            cnt_reg      <= '0;
            allow_reg    <= '0;
            prefix_reg   <= 1'b0;
            suffix_reg   <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            fm_valid_reg <= fm_valid_next;
            cnt_reg      <= cnt_next;
            allow_reg    <= allow_next;
            prefix_reg   <= prefix_next;
            suffix_reg   <= suffix_next;
        end
    end

    always_ff @(posedge aclk) begin
        fm_idx_reg <= fm_idx_next;
    end

    a_count_le_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= pos_reg)
        else $error("match count exceeds bytes seen");

    a_allow_le_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        allow_reg <= pos_reg)
        else $error("next allowed start beyond current position");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        step && last_item |=> pos_reg == '0 && !fm_valid_reg && cnt_reg == '0)
        else $error("stream state not cleared after last beat");

endmodule

// File: hdl/byte_substring_matcher.sv
// Top level of the byte substring matcher: configuration registers, window
// bound resolution, the cell chain, the trackers and the result register.
// Depends on bsm_pkg, bsm_cell and bsm_track.
//
// Takes one text byte per clock on the s_ side and gives one result beat on the
// m_ side for every input beat with tlast set, in the cycle after that beat. The
// needle compare is a row of 16 cells that shift the text along and check the
// newest needle-length bytes in parallel with the byte being taken. s_tready
// drops while a finished result waits for m_tready, and in the cycle after a
// configuration write while the window bounds are resolved into registers.
module byte_substring_matcher (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // text_byte[7:0]
    input  logic                          s_tuser,   // has_byte
    input  logic                          s_tlast,   // last_item
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata    // found, match_index[17:1],
                                                     // match_count[34:18], zero pad
);
    import bsm_pkg::*;

    logic [CFG_W-1:0]  needle_lo_reg;
    logic [CFG_W-1:0]  needle_hi_reg;
    logic [LEN_W-1:0]  needle_len_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [POS_W-1:0]  text_len_reg;
    logic [BND_W-1:0]  win_start_reg;
    logic [BND_W-1:0]  win_end_reg;
    logic [POS_W-1:0]  from_reg;
    logic [POS_W-1:0]  to_reg;
    logic              cfg_settle_reg;

    logic [POS_W-1:0]    from_next, to_next;
    logic [NEEDLE_W-1:0] needle;
    logic [LEN_W-1:0]    len_act;
    bsm_cfg_t            cfg;
    bsm_res_t            res;
    logic                in_fire;
    logic                shift_en;

    logic [CHAR_W-1:0]   cell_data [NUM_CELLS];
    logic [NUM_CELLS:0]  chain;

    logic                out_valid_reg;
    bsm_res_t            out_res_reg;

    function automatic logic [POS_W-1:0] resolve_bound(
        input logic [BND_W-1:0] v,
        input logic [POS_W-1:0] n
    );
        logic signed [BND_W:0] t;
        logic signed [BND_W:0] ns;
        t  = $signed({v[BND_W-1], v});
        ns = $signed({2'b00, n});
        if (t < 0) begin
            t = t + ns;
            if (t < 0) begin
                t = '0;
            end
        end
        if (t > ns) begin
            t = ns;
        end
        return t[POS_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_lo_reg  <= '0;
            needle_hi_reg  <= '0;
            needle_len_reg <= LEN_W'(1);
            mode_reg       <= MODE_FIND;
            text_len_reg   <= '0;
            win_start_reg  <= '0;
            win_end_reg    <= BND_W'(131071);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NEEDLE_LO:  needle_lo_reg  <= cfg_data;
                CFG_NEEDLE_HI:  needle_hi_reg  <= cfg_data;
                CFG_NEEDLE_LEN: needle_len_reg <= cfg_data[LEN_W-1:0];
                CFG_MODE:       mode_reg       <= cfg_data[MODE_W-1:0];
                CFG_TEXT_LEN:   text_len_reg   <= cfg_data[POS_W-1:0];
                CFG_WIN_START:  win_start_reg  <= cfg_data[BND_W-1:0];
                CFG_WIN_END:    win_end_reg    <= cfg_data[BND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        from_next = resolve_bound(win_start_reg, text_len_reg);
        to_next   = resolve_bound(win_end_reg, text_len_reg);
        if (to_next < from_next) begin
            to_next = from_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            from_reg <= '0;
            to_reg   <= '0;
        end else begin
            from_reg <= from_next;
            to_reg   <= to_next;
        end
    end

    // hold input off while the resolved bounds catch up with a write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_settle_reg <= 1'b0;
        end else begin
            cfg_settle_reg <= cfg_wr_en;
        end
    end

    assign needle  = {needle_hi_reg, needle_lo_reg};
    assign len_act = (needle_len_reg > MAX_NEEDLE_LEN) ? MAX_NEEDLE_LEN : needle_len_reg;

    assign cfg.len_zero = (len_act == '0);
    assign cfg.len_act  = len_act;
    assign cfg.mode     = mode_reg;
    assign cfg.from     = from_reg;
    assign cfg.to       = to_reg;

    assign s_tready = !cfg_settle_reg && (!out_valid_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;
    assign shift_en = in_fire && s_tuser;

    assign cell_data[0] = s_tdata;
    assign chain[0]     = 1'b1;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cells
        localparam logic [LEN_W-1:0] CellIdx = LEN_W'(i);
        logic              active;
        logic [LEN_W-1:0]  pat_idx;
        logic [CHAR_W-1:0] pat_char;
        logic [CHAR_W-1:0] data_out;

        assign active   = CellIdx < len_act;
        assign pat_idx  = len_act - CellIdx - LEN_W'(1);
        assign pat_char = needle_char(needle, pat_idx[CIDX_W-1:0]);

        bsm_cell u_cell (
            .aclk      (aclk),
            .shift_en  (shift_en),
            .data_in   (cell_data[i]),
            .pat_char  (pat_char),
            .active    (active),
            .chain_in  (chain[i]),
            .data_out  (data_out),
            .chain_out (chain[i+1])
        );

        if (i < NUM_CELLS - 1) begin : g_link
            assign cell_data[i+1] = data_out;
        end
    end

    bsm_track u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (in_fire),
        .has_byte  (s_tuser),
        .last_item (s_tlast),
        .chain_hit (chain[NUM_CELLS]),
        .cfg       (cfg),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire && s_tlast) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && s_tlast) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_res_reg.count, out_res_reg.index, out_res_reg.found};

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result raised without a last beat");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while a result is blocked");

endmodule

// File: sim/byte_substring_matcher_tb.sv
// Self-checking bench for byte_substring_matcher: streams texts under many needle and
// window settings and compares every result beat against an in-bench match predictor.
// Depends on bsm_pkg and hdl/byte_substring_matcher.sv.
module byte_substring_matcher_tb;
    import bsm_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TEXT_CAP     = 65536;
    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        logic        found;
        logic [16:0] index;
        logic [16:0] count;
    } search_result_t;

    typedef logic [7:0] text_q_t[$];

    class matcher_scoreboard;
        logic [63:0]       needle_lo, needle_hi;
        logic [LEN_W-1:0]  needle_len;
        logic [MODE_W-1:0] mode;
        logic [16:0]       text_len;
        logic [17:0]       win_start, win_end;
        logic [127:0]      recent;
        int                pos, first_start, hits, next_start;
        bit                at_prefix, at_suffix;
        search_result_t    pending_results[$];
        int                mismatches, checked;

        function void reset_all();
            needle_lo  = '0;
            needle_hi  = '0;
            needle_len = 1;
            mode       = MODE_FIND;
            text_len   = '0;
            win_start  = '0;
            win_end    = 18'd131071;
            mismatches = 0;
            checked    = 0;
            clear_text();
        endfunction

        function void clear_text();
            recent      = '0;
            pos         = 0;
            first_start = -1;
            hits        = 0;
            next_start  = 0;
            at_prefix   = 0;
            at_suffix   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
            case (idx)
                CFG_NEEDLE_LO:  needle_lo  = val;
                CFG_NEEDLE_HI:  needle_hi  = val;
                CFG_NEEDLE_LEN: needle_len = val[LEN_W-1:0];
                CFG_MODE:       mode       = val[MODE_W-1:0];
                CFG_TEXT_LEN:   text_len   = val[16:0];
                CFG_WIN_START:  win_start  = val[17:0];
                CFG_WIN_END:    win_end    = val[17:0];
                default: ;
            endcase
        endfunction

        function int active_len();
            return (needle_len > NUM_CELLS) ? NUM_CELLS : int'(needle_len);
        endfunction

        function logic [7:0] needle_at(int i);
            logic [127:0] all;
            all = {needle_hi, needle_lo};
            return all[8*i +: 8];
        endfunction

        function int resolve_bound(logic [17:0] raw, int n);
            int v;
            v = $signed({{14{raw[17]}}, raw});
            if (v < 0) begin
                v += n;
                if (v < 0) v = 0;
            end
            if (v > n) v = n;
            return v;
        endfunction

        // one accepted input beat
        function void take_beat(logic [7:0] b, logic has, logic lst);
            int len, from, to, s;
            bit hit;
            search_result_t r;
            len  = active_len();
            from = resolve_bound(win_start, int'(text_len));
            to   = resolve_bound(win_end, int'(text_len));
            if (to < from) to = from;
            if (has && pos < TEXT_CAP) begin
                recent = {recent[119:0], b};
                hit = 0;
                if (len > 0 && pos + 1 >= len) begin
                    hit = 1;
                    for (int i = 0; i < len; i++)
                        if (recent[8*i +: 8] != needle_at(len - 1 - i)) hit = 0;
                end
                if (hit) begin
                    s = pos + 1 - len;
                    if (first_start < 0 && s >= from && pos + 1 <= to) first_start = s;
                    if (s >= next_start) begin
                        hits++;
                        next_start = pos + 1;
                    end
                    if (s == 0) at_prefix = 1;
                end
                at_suffix = hit;
                pos++;
            end
            if (lst) begin
                r.found = 0;
                r.index = '1;
                r.count = '0;
                case (mode)
                    MODE_FIND: begin
                        s = (len == 0) ? from : first_start;
                        r.found = (s >= 0);
                        r.index = 17'(s);
                    end
                    MODE_COUNT: begin
                        s = (len == 0) ? pos + 1 : hits;
                        r.found = (s != 0);
                        r.count = 17'(s);
                    end
                    MODE_PREFIX: r.found = (len == 0) || at_prefix;
                    default:     r.found = (len == 0) || at_suffix;
                endcase
                pending_results.push_back(r);
                clear_text();
            end
        endfunction

        function void check_result(logic [39:0] beat);
            search_result_t want;
            checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result beat %h arrived with none expected", beat);
                return;
            end
            want = pending_results.pop_front();
            if (beat[0] !== want.found || beat[17:1] !== want.index
                    || beat[34:18] !== want.count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected found=%0b index=%0d count=%0d, got %0b %0d %0d",
                             checked, want.found, $signed(want.index), want.count,
                             beat[0], $signed(beat[17:1]), beat[34:18]);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [39:0]          m_tdata;

    int cycles = 0;
    int src_idle_pct = 26;
    int sink_idle_pct = 68;
    int hold_req = 0;
    int hold_left = 0;
    int items_sent = 0;
    int texts_sent = 0;
    matcher_scoreboard sb;

    byte_substring_matcher uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    // bound resolution registers the bounds in the cycle after the write
    task automatic finish_writes();
        cfg_wr_en <= 1'b0;
        repeat (3) @(negedge aclk);
    endtask

    task automatic setup(input logic [63:0] lo, input logic [63:0] hi,
                         input logic [LEN_W-1:0] nlen, input logic [MODE_W-1:0] md,
                         input logic [16:0] tlen, input logic [17:0] ws,
                         input logic [17:0] we, input bit junk);
        logic [63:0] fill;
        fill = junk ? {$urandom, $urandom} : '0;
        write_reg(CFG_NEEDLE_LO, lo);
        write_reg(CFG_NEEDLE_HI, hi);
        write_reg(CFG_NEEDLE_LEN, {fill[63:LEN_W], nlen});
        write_reg(CFG_MODE, {fill[63:MODE_W], md});
        write_reg(CFG_TEXT_LEN, {fill[63:17], tlen});
        write_reg(CFG_WIN_START, {fill[63:18], ws});
        write_reg(CFG_WIN_END, {fill[63:18], we});
        if (junk && $urandom_range(3) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
        finish_writes();
    endtask

    task automatic send_beat(input logic [7:0] b, input logic has, input logic lst);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= has;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        sb.take_beat(b, has, lst);
        if (has || lst) items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input text_q_t txt, input int marker_pct);
        bit tail_marker;
        tail_marker = (txt.size() == 0) || ($urandom_range(99) < 12);
        foreach (txt[i]) begin
            if ($urandom_range(99) < marker_pct) send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(txt[i], 1'b1, !tail_marker && i == txt.size() - 1);
        end
        if (tail_marker) send_beat(8'($urandom), 1'b0, 1'b1);
        texts_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h61;
            default: return 8'h62;
        endcase
    endfunction

    function automatic logic [17:0] rand_bound(int n);
        case ($urandom_range(9))
            0:       return 18'h20000;
            1:       return 18'h1ffff;
            2:       return 18'($urandom);
            3:       return '0;
            default: return 18'($urandom_range(2 * n + 6) - (n + 3));
        endcase
    endfunction

    // text spliced from needle copies, partial copies and loose bytes
    function automatic text_q_t make_text(int want_len);
        text_q_t t;
        int nl, cut;
        nl = sb.active_len();
        while (t.size() < want_len) begin
            case ($urandom_range(4))
                0: for (int k = 0; k < nl; k++) t.push_back(sb.needle_at(k));
                1: begin
                    cut = $urandom_range(nl);
                    for (int k = 0; k < cut; k++) t.push_back(sb.needle_at(k));
                end
                2: t.push_back(nl > 0 ? sb.needle_at($urandom_range(nl - 1)) : pick_alpha());
                3: t.push_back(pick_alpha());
                default: t.push_back(8'($urandom));
            endcase
        end
        while (t.size() > want_len) void'(t.pop_back());
        return t;
    endfunction

    function automatic int rand_text_len();
        return ($urandom_range(99) < 85) ? $urandom_range(24) : $urandom_range(25, 60);
    endfunction

    task automatic random_setup(input int plen);
        logic [63:0]      lo, hi;
        logic [LEN_W-1:0] nl;
        int               tl, sel;
        case ($urandom_range(9))
            0:       nl = '0;
            1:       nl = LEN_W'($urandom_range(7, 16));
            2:       nl = LEN_W'($urandom_range(17, 31));
            default: nl = LEN_W'($urandom_range(1, 6));
        endcase
        if ($urandom_range(1)) begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
        end else begin
            for (int i = 0; i < 8; i++) begin
                lo[8*i +: 8] = pick_alpha();
                hi[8*i +: 8] = pick_alpha();
            end
        end
        sel = $urandom_range(9);
        tl = (sel < 7) ? plen : (sel < 9) ? $urandom_range(plen + 8) : $urandom_range(TEXT_CAP);
        setup(lo, hi, nl, MODE_W'($urandom_range(3)), 17'(tl),
              rand_bound(tl), rand_bound(tl), 1'b1);
    endtask

    task automatic random_batch();
        int plen;
        plen = rand_text_len();
        random_setup(plen);
        repeat ($urandom_range(1, 4)) begin
            send_text(make_text($urandom_range(1) ? plen : rand_text_len()), 10);
        end
        wait_idle();
    endtask

    task automatic directed_tests();
        text_q_t t;
        // reset settings: one zero byte needle, zero declared length closes the window
        t = '{8'h00, 8'h00};
        send_text(t, 0);
        wait_idle();
        // find with a negative window start
        setup(64'h636261, '0, 5'd3, MODE_FIND, 17'd6, -18'sd3, 18'h1ffff, 1'b0);
        t = '{8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63};
        send_text(t, 0);
        wait_idle();
        // greedy count skips overlaps; marker inside the text
        setup(64'h6161, '0, 5'd2, MODE_COUNT, 17'd5, '0, 18'h1ffff, 1'b0);
        t = '{8'h61, 8'h61, 8'h61, 8'h61, 8'h61};
        send_text(t, 50);
        wait_idle();
        setup(64'h00ff, '0, 5'd2, MODE_PREFIX, 17'd3, '0, 18'h1ffff, 1'b0);
        t = '{8'hff, 8'h00, 8'hff};
        send_text(t, 0);
        wait_idle();
        setup(64'hff00, '0, 5'd2, MODE_SUFFIX, 17'd3, '0, 18'h1ffff, 1'b0);
        t = '{8'h00, 8'hff, 8'h00};
        send_text(t, 0);
        wait_idle();
        // empty needle, window start resolved to the top of the text range
        setup('1, '1, 5'd0, MODE_FIND, 17'd65536, 18'h1ffff, 18'h1ffff, 1'b0);
        t = {};
        send_text(t, 0);
        wait_idle();
        setup('1, '1, 5'd0, MODE_COUNT, '0, '0, 18'h1ffff, 1'b0);
        send_text(t, 0);
        wait_idle();
        // length above the cell count acts as full width
        setup('1, '1, 5'd31, MODE_COUNT, 17'd3, 18'h20000, 18'h20000, 1'b0);
        t = '{8'hff, 8'hff, 8'hff};
        send_text(t, 0);
        wait_idle();
        write_reg(CFG_UNUSED, '1);
        setup(64'h61, '0, 5'd1, MODE_FIND, 17'd2, 18'h20000, 18'h1ffff, 1'b0);
        t = '{8'h62, 8'h61};
        send_text(t, 0);
        wait_idle();
    endtask

    initial begin
        int start_items;
        sb = new;
        sb.reset_all();
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        directed_tests();

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct  = (ph == 0) ? 26 : (ph == 1) ? 68 : 0;
            sink_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 26 : 0;
            if (ph == 2) begin
                // result side held off while short texts keep coming
                random_setup(3);
                hold_req = HOLD_CYCLES;
                repeat (8) send_text(make_text($urandom_range(4)), 10);
                wait_idle();
            end
            start_items = items_sent;
            while (items_sent - start_items < RANDOM_ITEMS / 3) random_batch();
        end

        $display("Ran %0d texts (%0d items) through find, count, prefix and suffix modes;",
                 texts_sent, items_sent);
        $display("%0d results checked, incl. empty needles, clamped windows and a %0d-cycle stall",
                 sb.checked, HOLD_CYCLES);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
